// ===== rtl/prr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package prr_pkg;

   // Word kinds carried in req_tuser
   localparam logic [1:0] KIND_AUDIO = 2'd0;
   localparam logic [1:0] KIND_COEF  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // Register indexes on the csr port
   localparam logic CSR_UP_FACTOR   = 1'b0;
   localparam logic CSR_DOWN_FACTOR = 1'b1;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 18;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int FACTOR_W = 4;
   localparam int PHASE_W  = 5;
   localparam int CIDX_W   = 7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_EMIT
   } state_type;

   // Per-cycle strobes from the sequencer to every lane
   typedef struct packed {
      logic shift;
      logic clear;
      logic rd;
      logic prod_en;
      logic acc_en;
      logic acc_first;
      logic scale_en;
      logic sat_en;
   } lane_ctrl_type;

   typedef struct packed {
      logic load;
      logic last;
   } merge_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/prr_mac_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prr_mac_lane #(
   parameter int TAPS = 16
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire prr_pkg::lane_ctrl_type ctrl,
   input  wire [$clog2(TAPS)-1:0]      tap,
   input  wire signed [15:0]           sample,
   input  wire signed [17:0]           coef,
   output logic signed [15:0]          result
);

   localparam int ACC_W = prr_pkg::PROD_W + $clog2(TAPS);
   localparam int SC_W  = ACC_W + 16;

   logic signed [15:0]          hist_ff [TAPS];
   logic signed [15:0]          hsamp_ff;
   logic signed [prr_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic signed [SC_W-1:0]      scaled_ff, scaled_in;
   logic signed [SC_W:0]        bias, biased, quot;
   logic signed [15:0]          res_ff, res_in;

   // History line: newest word at the top, oldest at index 0
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         for (int i = 0; i < TAPS; i++) hist_ff[i] <= '0;
      end else if (ctrl.shift) begin
         for (int i = 0; i < TAPS - 1; i++) hist_ff[i] <= hist_ff[i+1];
         hist_ff[TAPS-1] <= sample;
      end
   end

   assign prod_in   = prr_pkg::PROD_W'(hsamp_ff) * prr_pkg::PROD_W'(coef);
   assign acc_in    = (ctrl.acc_first ? ACC_W'(0) : acc_ff) + ACC_W'(prod_ff);
   // acc * 32767 as (acc << 15) - acc
   assign scaled_in = (SC_W'(acc_ff) <<< 15) - SC_W'(acc_ff);

   // Truncate toward zero: bias negative values before the arithmetic shift
   assign bias   = scaled_ff[SC_W-1] ? (SC_W+1)'(32'sh7fff_ffff) : '0;
   assign biased = (SC_W+1)'(scaled_ff) + bias;
   assign quot   = biased >>> 31;

   always_comb begin
      if (quot > (SC_W+1)'(32767)) begin
         res_in = 16'sh7fff;
      end else if (quot < (SC_W+1)'(-32768)) begin
         res_in = -16'sh8000;
      end else begin
         res_in = 16'(quot);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd)       hsamp_ff  <= hist_ff[tap];
      if (ctrl.prod_en)  prod_ff   <= prod_in;
      if (ctrl.acc_en)   acc_ff    <= acc_in;
      if (ctrl.scale_en) scaled_ff <= scaled_in;
      if (ctrl.sat_en)   res_ff    <= res_in;
   end

   assign result = res_ff;

endmodule

`default_nettype wire

// ===== rtl/prr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prr_ctrl #(
   parameter int TAPS       = 16,
   parameter int MAX_PHASES = 8
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire [1:0]                    kind,
   input  wire [6:0]                    coef_index,
   input  wire signed [17:0]            coef_value,
   input  wire                          csr_we,
   input  wire                          csr_addr,
   input  wire [3:0]                    csr_wdata,
   input  wire                          merge_free,
   output prr_pkg::lane_ctrl_type       lane_ctrl,
   output logic [$clog2(TAPS)-1:0]      tap,
   output logic signed [17:0]           coef,
   output prr_pkg::merge_ctrl_type      merge_ctrl
);

   localparam int TAP_W      = $clog2(TAPS);
   localparam int STORE_SIZE = TAPS * MAX_PHASES;
   localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
   localparam int BANK_W     = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
   localparam int CNT_W      = $clog2(TAPS + 4);
   localparam int PW         = prr_pkg::PHASE_W;

   prr_pkg::state_type state_ff, state_in;
   logic [3:0]        up_ff, down_ff;
   logic [PW-1:0]     phase_ff, phase_in, p_eff, q_eff, phase_step;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              accept, coef_we;
   logic [ADDR_W-1:0] rd_addr;
   logic signed [17:0] coef_mem [STORE_SIZE];
   logic signed [17:0] coef_rd_ff;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff   <= 4'd1;
         down_ff <= 4'd1;
      end else if (csr_we) begin
         case (csr_addr)
            prr_pkg::CSR_UP_FACTOR:   up_ff   <= csr_wdata;
            prr_pkg::CSR_DOWN_FACTOR: down_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Zero factor acts as one; the bank count is capped at the store's banks
   always_comb begin
      if (up_ff == 4'd0)                       p_eff = PW'(1);
      else if (PW'(up_ff) > PW'(MAX_PHASES))   p_eff = PW'(MAX_PHASES);
      else                                     p_eff = PW'(up_ff);
      q_eff = (down_ff == 4'd0) ? PW'(1) : PW'(down_ff);
   end

   assign phase_step = phase_ff + q_eff;

   assign tap     = cnt_ff[TAP_W-1:0];
   assign rd_addr = ADDR_W'(ADDR_W'(phase_ff[BANK_W-1:0]) * ADDR_W'(TAPS)) + ADDR_W'(tap);
   assign coef_we = accept && (kind == prr_pkg::KIND_COEF) && (32'(coef_index) < STORE_SIZE);

   always_ff @(posedge clock) begin
      if (coef_we) coef_mem[ADDR_W'(coef_index)] <= coef_value;
      coef_rd_ff <= coef_mem[rd_addr];
   end

   assign coef = coef_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prr_pkg::ST_IDLE;
         phase_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      req_ready  = 1'b0;
      lane_ctrl  = '0;
      merge_ctrl = '0;
      case (state_ff)
         prr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               case (kind)
                  prr_pkg::KIND_AUDIO: begin
                     lane_ctrl.shift = 1'b1;
                     if (phase_ff < p_eff) begin
                        state_in = prr_pkg::ST_MAC;
                        cnt_in   = '0;
                     end else begin
                        phase_in = phase_ff - p_eff;
                     end
                  end
                  prr_pkg::KIND_CLEAR: begin
                     lane_ctrl.clear = 1'b1;
                     phase_in        = '0;
                  end
                  default: ;
               endcase
            end
         end
         prr_pkg::ST_MAC: begin
            // read into hsamp_ff, multiply into prod_ff, accumulate into acc_ff, then scale, saturate
            lane_ctrl.rd        = cnt_ff < CNT_W'(TAPS);
            lane_ctrl.prod_en   = (cnt_ff >= CNT_W'(1)) && (cnt_ff <= CNT_W'(TAPS));
            lane_ctrl.acc_en    = (cnt_ff >= CNT_W'(2)) && (cnt_ff <= CNT_W'(TAPS + 1));
            lane_ctrl.acc_first = cnt_ff == CNT_W'(2);
            lane_ctrl.scale_en  = cnt_ff == CNT_W'(TAPS + 2);
            lane_ctrl.sat_en    = cnt_ff == CNT_W'(TAPS + 3);
            if (cnt_ff == CNT_W'(TAPS + 3)) begin
               state_in = prr_pkg::ST_EMIT;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         prr_pkg::ST_EMIT: begin
            if (merge_free) begin
               merge_ctrl.load = 1'b1;
               merge_ctrl.last = !(phase_step < p_eff);
               if (phase_step < p_eff) begin
                  phase_in = phase_step;
                  state_in = prr_pkg::ST_MAC;
                  cnt_in   = '0;
               end else begin
                  phase_in = phase_step - p_eff;
                  state_in = prr_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = prr_pkg::ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/prr_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prr_merge (
   input  wire                          clock,
   input  wire                          reset,
   input  wire prr_pkg::merge_ctrl_type merge_ctrl,
   input  wire signed [15:0]            res_0,
   input  wire signed [15:0]            res_1,
   output logic                         free,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [31:0]                  rsp_tdata,
   output logic                         rsp_tlast
);

   logic        valid_ff;
   logic [31:0] data_ff;
   logic        last_ff;

   assign free = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (merge_ctrl.load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   // Pack both lanes into one output word
   always_ff @(posedge clock) begin
      if (merge_ctrl.load) begin
         data_ff <= {res_1, res_0};
         last_ff <= merge_ctrl.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// ===== rtl/polyphase_rational_resampler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Stereo rational P/Q polyphase resampler.
// req_ channel: one word per audio frame, coefficient load or history clear,
//   selected by req_tuser. An audio frame yields 0 to 8 output words on the
//   rsp_ channel; rsp_tlast marks the final word a frame produced.
// csr_ port: index 0 is the up factor P, index 1 the down factor Q. Write
//   only while the block is idle.
// Each channel has its own MAC lane (history line, one multiplier); both
//   lanes share the coefficient RAM read and are packed by the output stage.
// Sequencing: each output word takes TAPS coefficient reads through the
//   single RAM read port, pipeline fill, scale, saturate and hand-off. A
//   frame with outputs holds req_tready low until its last word is handed
//   off; coefficient, clear and silent frames are taken in the idle state
//   without leaving it.
// The output register holds one word, so the next frame is accepted while
//   the last word of the previous one still waits. A stalled receiver holds
//   the word and the sequencer waits before handing off the next one.
// Reset (synchronous) clears history, phase and both factors to 1; the
//   coefficient RAM keeps its contents and must be loaded before use.

module polyphase_rational_resampler_core #(
   parameter int TAPS       = 16,
   parameter int MAX_PHASES = 8,
   parameter int CHANNELS   = 2
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [63:0] req_tdata,   // sample_0, sample_1, coef_index, coef_value, zero fill
   input  wire [1:0]  req_tuser,   // kind
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [31:0] rsp_tdata,  // out_0, out_1
   output logic       rsp_tlast,   // last
   input  wire        csr_we,
   input  wire        csr_addr,
   input  wire [3:0]  csr_wdata
);

   prr_pkg::lane_ctrl_type  lane_ctrl;
   prr_pkg::merge_ctrl_type merge_ctrl;
   logic [$clog2(TAPS)-1:0] tap;
   logic signed [17:0]      coef;
   logic signed [15:0]      sample_0, sample_1, res_0, res_1;
   logic [6:0]              coef_index;
   logic signed [17:0]      coef_value;
   logic                    merge_free;

   // Unpack the request word
   assign sample_0   = req_tdata[15:0];
   assign sample_1   = req_tdata[31:16];
   assign coef_index = req_tdata[38:32];
   assign coef_value = req_tdata[56:39];

   prr_ctrl #(
      .TAPS       (TAPS),
      .MAX_PHASES (MAX_PHASES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .kind       (req_tuser),
      .coef_index (coef_index),
      .coef_value (coef_value),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .merge_free (merge_free),
      .lane_ctrl  (lane_ctrl),
      .tap        (tap),
      .coef       (coef),
      .merge_ctrl (merge_ctrl)
   );

   prr_mac_lane #(.TAPS(TAPS)) u_lane_0 (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lane_ctrl),
      .tap    (tap),
      .sample (sample_0),
      .coef   (coef),
      .result (res_0)
   );

   // Second lane only for stereo; mono drives channel 1 as silence
   if (CHANNELS > 1) begin : g_lane_1
      prr_mac_lane #(.TAPS(TAPS)) u_lane_1 (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .tap    (tap),
         .sample (sample_1),
         .coef   (coef),
         .result (res_1)
      );
   end else begin : g_mono
      assign res_1 = '0;
   end

   prr_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .merge_ctrl (merge_ctrl),
      .res_0      (res_0),
      .res_1      (res_1),
      .free       (merge_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== rtl/prr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prr_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata,
   input wire        rsp_tlast
);

   // Hold a stalled output word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled output word changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   // A result needs the whole MAC pass; none can appear right after an accept
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("output word appeared one cycle after accept");

   // More words of the frame follow, so the input stays blocked
   a_busy_mid_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input ready in the middle of a frame's output");

endmodule

bind polyphase_rational_resampler_core prr_checker u_prr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
